### rtl/clq_pkg.sv
// Shared command, status and state definitions for the circular queue block.
`default_nettype none

package clq_pkg;

    // Field widths fixed by the interface.
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int CFG_W    = 5;

    // Capacity after reset.
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_LIST = 3'b100
    } t_state;

endpackage

`default_nettype wire

### rtl/circular_queue_with_listing_unit.sv
// Top level: ring-buffer queue with programmable capacity and a listing command.
// Add, or delete or list on an empty queue: one final beat in the next cycle, never busy.
// Delete of a held word: the word is read, then registered as the beat; busy for one cycle.
// List of N held words: N beats one per cycle, each read then registered; busy while listing.
// Reset (synchronous, active low) empties the queue and sets capacity to 16; slots keep data.
// The receiver cannot stall result beats; a new command is taken whenever busy is low.
`default_nettype none

module circular_queue_with_listing_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    output logic                                 o_busy,
    input  wire logic [clq_pkg::CMD_W-1:0]       i_cmd,
    input  wire logic signed [clq_pkg::DATA_W-1:0] i_value,
    input  wire logic                            i_cfg_we,
    input  wire logic [clq_pkg::CFG_W-1:0]       i_cfg_wdata,
    output logic                                 o_valid,
    output logic [clq_pkg::STATUS_W-1:0]         o_status,
    output logic signed [clq_pkg::DATA_W-1:0]    o_data,
    output logic                                 o_last
);
    import clq_pkg::*;

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW   = $clog2(DEPTH + 1);
    localparam int CMPW = (OW > CFG_W) ? OW : CFG_W;

    // Step an index forward, wrapping at the effective capacity.
    function automatic logic [AW-1:0] f_adv(input logic [AW-1:0] idx,
                                            input logic [OW-1:0] cap);
        logic [OW-1:0] nxt;
        nxt = OW'(idx) + OW'(1);
        return (nxt >= cap) ? '0 : AW'(nxt);
    endfunction

    // Control state.
    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_cap, n_cap;
    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [OW-1:0]    r_occ, n_occ;
    logic [AW-1:0]    r_idx, n_idx;
    logic [OW-1:0]    r_left, n_left;

    // Output beat registers.
    logic                     r_valid, n_valid;
    logic [STATUS_W-1:0]      r_status, n_status;
    logic signed [DATA_W-1:0] r_data, n_data;
    logic                     r_last, n_last;

    // Slot memory and its ports.
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic              w_wr_en;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;

    logic [OW-1:0] w_cap;
    logic          w_acc;
    logic          w_full;
    logic          w_empty;

    // Effective capacity: zero counts as one, anything above the depth as the depth.
    always_comb begin
        if (r_cap == '0) begin
            w_cap = OW'(1);
        end else if (CMPW'(r_cap) > CMPW'(DEPTH)) begin
            w_cap = OW'(DEPTH);
        end else begin
            w_cap = OW'(r_cap);
        end
    end

    assign w_acc   = i_start && (r_state == ST_IDLE);
    assign w_full  = (r_occ >= w_cap);
    assign w_empty = (r_occ == '0);

    // Command sequencing, pointer update and result formation.
    always_comb begin
        n_state   = r_state;
        n_cap     = r_cap;
        n_head    = r_head;
        n_tail    = r_tail;
        n_occ     = r_occ;
        n_idx     = r_idx;
        n_left    = r_left;
        n_valid   = 1'b0;
        n_status  = STAT_OK;
        n_data    = '0;
        n_last    = 1'b1;
        w_wr_en   = 1'b0;
        w_rd_en   = 1'b0;
        w_rd_addr = r_head;

        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (i_cmd)
                        CMD_ADD: begin
                            n_valid = 1'b1;
                            if (w_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                w_wr_en = 1'b1;
                                n_tail  = f_adv(r_tail, w_cap);
                                n_occ   = r_occ + OW'(1);
                            end
                        end
                        CMD_DEL: begin
                            if (w_empty) begin
                                n_valid  = 1'b1;
                                n_status = STAT_EMPTY;
                            end else begin
                                w_rd_en = 1'b1;
                                n_head  = f_adv(r_head, w_cap);
                                n_occ   = r_occ - OW'(1);
                                n_state = ST_READ;
                            end
                        end
                        CMD_LIST: begin
                            if (w_empty) begin
                                n_valid  = 1'b1;
                                n_status = STAT_EMPTY;
                            end else begin
                                w_rd_en = 1'b1;
                                n_idx   = f_adv(r_head, w_cap);
                                n_left  = r_occ;
                                n_state = ST_LIST;
                            end
                        end
                        default: begin
                            // No operation: nothing stored, no beat.
                        end
                    endcase
                end
            end
            ST_READ: begin
                // The head word read last cycle is now on the memory output.
                n_valid = 1'b1;
                n_data  = $signed(r_rd_data);
                n_state = ST_IDLE;
            end
            ST_LIST: begin
                // Emit the word fetched last cycle and fetch the next one.
                n_valid   = 1'b1;
                n_data    = $signed(r_rd_data);
                n_last    = (r_left == OW'(1));
                w_rd_en   = 1'b1;
                w_rd_addr = r_idx;
                n_idx     = f_adv(r_idx, w_cap);
                n_left    = r_left - OW'(1);
                if (r_left == OW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A capacity write empties the queue.
        if (i_cfg_we) begin
            n_cap  = i_cfg_wdata;
            n_head = '0;
            n_tail = '0;
            n_occ  = '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cap   <= CAP_RESET;
            r_head  <= '0;
            r_tail  <= '0;
            r_occ   <= '0;
            r_idx   <= '0;
            r_left  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cap   <= n_cap;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            r_idx   <= n_idx;
            r_left  <= n_left;
            r_valid <= n_valid;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_data   <= n_data;
        r_last   <= n_last;
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_tail] <= i_value;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_data   = r_data;
    assign o_last   = r_last;

endmodule

`default_nettype wire

### rtl/clq_checker.sv
// Port-level checker for the circular queue block, with its bind statement.
`default_nettype none

module clq_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_start,
    input wire logic                              o_busy,
    input wire logic [clq_pkg::CMD_W-1:0]         i_cmd,
    input wire logic                              o_valid,
    input wire logic [clq_pkg::STATUS_W-1:0]      o_status,
    input wire logic signed [clq_pkg::DATA_W-1:0] o_data,
    input wire logic                              o_last
);
    import clq_pkg::*;

    // An accepted add answers in the next cycle with a single final beat.
    a_add_answer : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd == CMD_ADD) |=>
            (o_valid && o_last && (o_status == STAT_OK || o_status == STAT_FULL)))
        else $error("add did not answer with one final beat");

    // An empty report carries zero data and ends the command.
    a_empty_beat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_EMPTY) |-> (o_data == '0 && o_last))
        else $error("empty beat with data or without last");

    // A listing that is not finished keeps the block busy.
    a_list_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_busy)
        else $error("listing beat without busy");

    // A listing streams without gaps until its final beat.
    a_list_gapless : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("gap inside a listing");

endmodule

bind circular_queue_with_listing_unit clq_checker u_clq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .i_cmd    (i_cmd),
    .o_valid  (o_valid),
    .o_status (o_status),
    .o_data   (o_data),
    .o_last   (o_last)
);

`default_nettype wire
